[rtl/ple_pkg.sv]
// Package for the positional list engine.
// Holds sizes, operation codes and the cell control type; no dependencies.
package ple_pkg;

    localparam int CAPACITY    = 16;
    localparam int ENTRY_WIDTH = 32;

    // Fixed field widths of the channels
    localparam int OPCODE_W = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 5;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_GET     = 3'd2,
        OP_REPLACE = 3'd3,
        OP_CLEAR   = 3'd4
    } ple_op_t;

    typedef logic [ENTRY_WIDTH-1:0] ple_entry_t;

    typedef struct packed {
        logic load_val;    // take the operand value
        logic take_left;   // shift towards the tail (insert)
        logic take_right;  // shift towards the head (remove)
        logic sel;         // drive held entry onto the read bus
    } ple_cell_ctrl_t;

endpackage

[rtl/ple_cmd_if.sv]
// Command channel of the positional list engine: valid/ready plus operation.
// Depends on ple_pkg for field widths.
interface ple_cmd_if
    import ple_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

[rtl/ple_rsp_if.sv]
// Response channel of the positional list engine: valid/ready plus result.
// Depends on ple_pkg for field widths.
interface ple_rsp_if
    import ple_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  length;

    modport source (output valid, output ok, output data, output length, input ready);
    modport sink   (input valid, input ok, input data, input length, output ready);
endinterface

[rtl/ple_cell.sv]
// One storage cell of the list chain: holds a single entry.
// Depends on ple_pkg; takes its neighbours' entries for shifting.
module ple_cell
    import ple_pkg::*;
(
    input  logic           clk,
    input  ple_cell_ctrl_t ctrl,
    input  ple_entry_t     value,
    input  ple_entry_t     left,
    input  ple_entry_t     right,
    output ple_entry_t     entry,
    output ple_entry_t     tap
);

    ple_entry_t entry_reg;
    ple_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_val)
        begin
            entry_next = value;
        end
        else if (ctrl.take_left)
        begin
            entry_next = left;
        end
        else if (ctrl.take_right)
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign tap   = ctrl.sel ? entry_reg : '0;

endmodule

[rtl/positional_list_engine.sv]
// Top level of the positional list engine: cell chain, count and result register.
// Depends on ple_pkg, ple_cmd_if, ple_rsp_if and ple_cell.
//
// Ordered list of up to CAPACITY entries addressed by 1-based position. Each
// command (insert, remove, get, replace, clear) completes in a single update: all
// cells shift or load in parallel, so there is one transfer per cycle in each
// direction while rsp.ready is high. The result sits in an output register;
// a new command is taken whenever that register is empty or is being drained
// in the same cycle, and its result is valid in the cycle after the transfer.
// No clearing pass after reset; only the entry count and valid flag are reset.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ple_cmd_if.sink   cmd,
    ple_rsp_if.source rsp
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              valid_reg;
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [LEN_W-1:0]  length_reg;

    logic              xfer;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              pos_nz;
    logic              ins_ok;
    logic              rem_ok;
    logic              get_ok;
    logic              rep_ok;
    ple_entry_t        value_e;
    ple_entry_t        rd_bus;

    ple_entry_t        entry_w [CAPACITY];
    ple_entry_t        tap_w   [CAPACITY];
    ple_cell_ctrl_t    ctrl_w  [CAPACITY];

    assign xfer      = cmd.valid && cmd.ready;
    assign cmd.ready = !valid_reg || rsp.ready;

    assign pos_ext = CMP_W'(cmd.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_nz  = (cmd.position != '0);
    assign value_e = ENTRY_WIDTH'(cmd.value);

    always_comb
    begin
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        get_ok = 1'b0;
        rep_ok = 1'b0;
        case (ple_op_t'(cmd.opcode))
            OP_INSERT:
            begin
                ins_ok = pos_nz && (pos_ext <= cnt_ext + CMP_W'(1))
                         && (cnt_ext < CMP_W'(CAPACITY));
            end
            OP_REMOVE:  rem_ok = pos_nz && (pos_ext <= cnt_ext);
            OP_GET:     get_ok = pos_nz && (pos_ext <= cnt_ext);
            OP_REPLACE: rep_ok = pos_nz && (pos_ext <= cnt_ext);
            default:
            begin
                ins_ok = 1'b0;
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] CELL_POS = CMP_W'(i + 1);

        always_comb
        begin
            ctrl_w[i].load_val   = xfer && (ins_ok || rep_ok) && (pos_ext == CELL_POS);
            ctrl_w[i].take_left  = xfer && ins_ok && (CELL_POS > pos_ext);
            ctrl_w[i].take_right = xfer && rem_ok && (CELL_POS >= pos_ext);
            ctrl_w[i].sel        = (get_ok || rep_ok) && (pos_ext == CELL_POS);
        end

        ple_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl_w[i]),
            .value (value_e),
            .left  ((i == 0) ? value_e : entry_w[(i == 0) ? 0 : i - 1]),
            .right ((i == CAPACITY - 1) ? entry_w[i] : entry_w[(i == CAPACITY - 1) ? i : i + 1]),
            .entry (entry_w[i]),
            .tap   (tap_w[i])
        );
    end

    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_bus = rd_bus | tap_w[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ok_next    = ins_ok || rem_ok || get_ok || rep_ok;
        data_next  = (get_ok || rep_ok) ? DATA_W'(rd_bus) : '0;
        if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (ple_op_t'(cmd.opcode) == OP_CLEAR)
        begin
            count_next = '0;
            ok_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (xfer)
            begin
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            ok_reg     <= ok_next;
            data_reg   <= data_next;
            length_reg <= LEN_W'(count_next);
        end
    end

    assign rsp.valid  = valid_reg;
    assign rsp.ok     = ok_reg;
    assign rsp.data   = data_reg;
    assign rsp.length = length_reg;

endmodule
